### sv/mbps_pkg.sv
// shared types and constants for the masked byte pattern search
// no dependencies

package mbps_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 40;
    localparam int OFFSET_BITS_DEF       = 32;

    localparam int PATTERN_WORDS = 5;
    localparam int REG_BYTES     = 40;
    localparam int WORD_BITS     = 64;
    localparam int LENGTH_BITS   = 6;
    localparam int CFG_INDEX_W   = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN0 = 4'd0,
        REG_PATTERN1 = 4'd1,
        REG_PATTERN2 = 4'd2,
        REG_PATTERN3 = 4'd3,
        REG_PATTERN4 = 4'd4,
        REG_CARE     = 4'd5,
        REG_LENGTH   = 4'd6,
        REG_BASE     = 4'd7
    } reg_index_t;

    typedef struct packed {
        logic [PATTERN_WORDS-1:0][WORD_BITS-1:0] pattern_word;
        logic [REG_BYTES-1:0]                    care_mask;
        logic [LENGTH_BITS-1:0]                  pattern_length;
        logic [WORD_BITS-1:0]                    region_base;
    } scan_cfg_t;

endpackage

### sv/mbps_cfg.sv
// configuration register file for the masked byte pattern search
// depends on mbps_pkg

module mbps_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbps_pkg::WORD_BITS-1:0]   cfg_data,
    output mbps_pkg::scan_cfg_t               cfg
);
    import mbps_pkg::*;

    scan_cfg_t cfg_reg;
    scan_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_PATTERN0, REG_PATTERN1, REG_PATTERN2, REG_PATTERN3, REG_PATTERN4: begin
                    cfg_next.pattern_word[cfg_index[2:0]] = cfg_data;
                end
                REG_CARE: begin
                    cfg_next.care_mask = cfg_data[REG_BYTES-1:0];
                end
                REG_LENGTH: begin
                    cfg_next.pattern_length = cfg_data[LENGTH_BITS-1:0];
                end
                REG_BASE: begin
                    cfg_next.region_base = cfg_data;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{pattern_word:   '0,
                         care_mask:      '0,
                         pattern_length: LENGTH_BITS'(1),
                         region_base:    '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/mbps_match.sv
// prefix match vector, byte counter and first-match tracking
// depends on mbps_pkg

module mbps_match #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  mbps_pkg::scan_cfg_t    cfg,
    output logic                   found,
    output logic [OFFSET_BITS-1:0] match_offset
);
    import mbps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [OFFSET_BITS-1:0]       count_reg;
    logic [MAX_PATTERN_BYTES-1:0] prefix_reg;
    logic                         seen_reg;
    logic [OFFSET_BITS-1:0]       offset_reg;

    logic [MAX_PATTERN_BYTES-1:0] byte_ok;
    logic [MAX_PATTERN_BYTES-1:0] prefix_next;
    logic [LENGTH_BITS:0]         len_ext;
    logic [LENGTH_BITS:0]         eff_len;
    logic [IDX_W-1:0]             len_m1;
    logic                         saturated;
    logic                         hit;
    logic                         seen_next;
    logic [OFFSET_BITS-1:0]       offset_next;

    // per pattern byte compare against the incoming byte
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cmp
        if (k < REG_BYTES) begin : g_reg
            assign byte_ok[k] = !cfg.care_mask[k] ||
                (data_byte == cfg.pattern_word[k / 8][(k % 8) * 8 +: 8]);
        end else begin : g_wild
            assign byte_ok[k] = 1'b1;
        end
        if (k == 0) begin : g_first
            assign prefix_next[k] = byte_ok[k];
        end else begin : g_rest
            assign prefix_next[k] = prefix_reg[k-1] & byte_ok[k];
        end
    end

    always_comb begin
        len_ext = {1'b0, cfg.pattern_length};
        if (len_ext == '0) begin
            eff_len = (LENGTH_BITS+1)'(1);
        end else if (len_ext > (LENGTH_BITS+1)'(MAX_PATTERN_BYTES)) begin
            eff_len = (LENGTH_BITS+1)'(MAX_PATTERN_BYTES);
        end else begin
            eff_len = len_ext;
        end
        len_m1 = IDX_W'(eff_len - (LENGTH_BITS+1)'(1));
    end

    assign saturated   = &count_reg;
    assign hit         = !saturated && !seen_reg && prefix_next[len_m1];
    assign seen_next   = seen_reg | hit;
    assign offset_next = hit ? (count_reg - OFFSET_BITS'(len_m1)) : offset_reg;

    assign found        = seen_next;
    assign match_offset = offset_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            prefix_reg <= '0;
            seen_reg   <= 1'b0;
            offset_reg <= '0;
        end else if (step) begin
            if (last_byte) begin
                count_reg  <= '0;
                prefix_reg <= '0;
                seen_reg   <= 1'b0;
                offset_reg <= '0;
            end else if (!saturated) begin
                count_reg  <= count_reg + OFFSET_BITS'(1);
                prefix_reg <= prefix_next;
                seen_reg   <= seen_next;
                offset_reg <= offset_next;
            end
        end
    end

endmodule

### sv/masked_byte_pattern_search.sv
// an item is registered on accept, and the result of the region's last item is then
// registered for the result port; one item per cycle, except while the last item
// waits on a stalled result port; rate set by the prefix match update over all bytes.
// reset (aresetn low, synchronous) clears the scan, empties both item registers
// and sets pattern_length to 1 and all other configuration registers to 0.
// depends on mbps_pkg, mbps_cfg, mbps_match

module masked_byte_pattern_search #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // data_byte
    input  logic                              s_tlast,   // last_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbps_pkg::WORD_BITS-1:0]   m_tdata,   // match_address
    output logic                              m_tuser,   // found
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbps_pkg::WORD_BITS-1:0]   cfg_data
);
    import mbps_pkg::*;

    scan_cfg_t              cfg;
    logic                   in_valid_reg;
    logic [7:0]             in_data_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic                   out_free;
    logic                   advance;
    logic                   found;
    logic [OFFSET_BITS-1:0] match_offset;

    mbps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .OFFSET_BITS       (OFFSET_BITS)
    ) u_match (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .data_byte    (in_data_reg),
        .last_byte    (in_last_reg),
        .cfg          (cfg),
        .found        (found),
        .match_offset (match_offset)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_found_reg  <= found;
            out_offset_reg <= match_offset;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_found_reg ? (cfg.region_base + WORD_BITS'(out_offset_reg))
                                    : '0;

endmodule

### tb/tb.sv
// testbench for masked_byte_pattern_search: streams byte regions, rewrites the pattern
// registers between regions and checks each found flag and match address against a predictor
// depends on mbps_pkg and the masked_byte_pattern_search rtl
`timescale 1ns / 1ps

module tb;
    import mbps_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] IDX_UNMAPPED_TOP = '1;

    typedef struct packed {
        logic                 found;
        logic [WORD_BITS-1:0] address;
    } scan_result_t;

    class scan_scoreboard;
        logic [WORD_BITS-1:0]       pattern_word [PATTERN_WORDS];
        logic [REG_BYTES-1:0]       care_mask;
        logic [LENGTH_BITS-1:0]     pattern_length;
        logic [WORD_BITS-1:0]       region_base;
        logic [7:0]                 window [MAX_PATTERN_BYTES_DEF];
        logic [OFFSET_BITS_DEF-1:0] byte_count;
        logic                       match_seen;
        logic [OFFSET_BITS_DEF-1:0] match_offset;
        scan_result_t               expected_hits [$];
        int                         errors;

        function new();
            foreach (pattern_word[i]) pattern_word[i] = '0;
            care_mask      = '0;
            pattern_length = LENGTH_BITS'(1);
            region_base    = '0;
            errors         = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (window[i]) window[i] = '0;
            byte_count   = '0;
            match_seen   = 1'b0;
            match_offset = '0;
        endfunction

        function int unsigned active_length();
            if (pattern_length == 0) return 1;
            if (pattern_length > MAX_PATTERN_BYTES_DEF) return MAX_PATTERN_BYTES_DEF;
            return pattern_length;
        endfunction

        function logic [7:0] pattern_byte(int unsigned k);
            return pattern_word[k / 8][8 * (k % 8) +: 8];
        endfunction

        function void apply_write(logic [CFG_INDEX_W-1:0] idx, logic [WORD_BITS-1:0] data);
            case (idx)
                REG_PATTERN0, REG_PATTERN1, REG_PATTERN2,
                REG_PATTERN3, REG_PATTERN4: pattern_word[idx] = data;
                REG_CARE:   care_mask      = data[REG_BYTES-1:0];
                REG_LENGTH: pattern_length = data[LENGTH_BITS-1:0];
                REG_BASE:   region_base    = data;
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] data, logic last);
            int unsigned  plen;
            bit           hit;
            scan_result_t res;
            plen = active_length();
            if (byte_count != '1) begin
                for (int i = MAX_PATTERN_BYTES_DEF - 1; i > 0; i--) window[i] = window[i-1];
                window[0]  = data;
                byte_count = byte_count + 1'b1;
                if (!match_seen && byte_count >= plen) begin
                    hit = 1'b1;
                    for (int unsigned k = 0; k < plen; k++)
                        if (k < REG_BYTES && care_mask[k] && window[plen-1-k] != pattern_byte(k))
                            hit = 1'b0;
                    if (hit) begin
                        match_seen   = 1'b1;
                        match_offset = byte_count - plen;
                    end
                end
            end
            if (last) begin
                res.found   = match_seen;
                res.address = match_seen ? region_base + WORD_BITS'(match_offset) : '0;
                expected_hits.push_back(res);
                clear_scan();
            end
        endfunction

        function void check_result(logic found, logic [WORD_BITS-1:0] address);
            scan_result_t want;
            if (expected_hits.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with none pending: found=%0b address=%h",
                             $realtime, found, address);
                return;
            end
            want = expected_hits.pop_front();
            if (found !== want.found || address !== want.address) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: expected found=%0b address=%h, got found=%0b address=%h",
                             $realtime, want.found, want.address, found, address);
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // data_byte
    logic                   s_tlast;   // last_byte
    logic                   m_tvalid;
    logic                   m_tready;
    logic [WORD_BITS-1:0]   m_tdata;   // match_address
    logic                   m_tuser;   // found
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_BITS-1:0]   cfg_data;

    scan_scoreboard sb;
    logic [7:0]     region_buf [$];
    int unsigned    bytes_sent = 0;
    bit             no_idle = 1'b0;

    masked_byte_pattern_search u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.apply_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        end
        m_tready <= no_idle || ($urandom_range(99) >= 31);
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        if (!no_idle && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        no_idle = bytes_sent >= 400 && bytes_sent < 600;
    endtask

    task automatic send_region_buf();
        foreach (region_buf[i]) send_byte(region_buf[i], i == region_buf.size() - 1);
        region_buf = {};
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic close_cfg();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_hits.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic random_config(input bit every_reg);
        logic [WORD_BITS-1:0] v;
        int unsigned          pick;
        for (int r = REG_PATTERN0; r <= REG_BASE; r++) begin
            if (every_reg || $urandom_range(1)) begin
                v    = {$urandom, $urandom};
                pick = $urandom_range(9);
                case (r)
                    REG_CARE: begin
                        if (pick == 0) v = '0;
                        else if (pick == 1) v = '1;
                        else if (pick > 5) v = v | {$urandom, $urandom};
                    end
                    REG_LENGTH: begin
                        case (pick)
                            0: v[LENGTH_BITS-1:0] = '0;
                            1: v[LENGTH_BITS-1:0] = LENGTH_BITS'(MAX_PATTERN_BYTES_DEF);
                            2: v[LENGTH_BITS-1:0] = '1;
                            3: v[LENGTH_BITS-1:0] = LENGTH_BITS'(1);
                            4, 5, 6: v[LENGTH_BITS-1:0] = LENGTH_BITS'($urandom_range(8, 2));
                            default: v[LENGTH_BITS-1:0] =
                                LENGTH_BITS'($urandom_range(MAX_PATTERN_BYTES_DEF, 1));
                        endcase
                    end
                    REG_BASE: begin
                        if (pick == 0) v = '1 - $urandom_range(15);
                        else if (pick == 1) v = '0;
                    end
                    default: begin
                        if (pick == 0) v = '0;
                        else if (pick == 1) v = '1;
                    end
                endcase
                write_cfg(CFG_INDEX_W'(r), v);
            end
        end
        if ($urandom_range(3) == 0)
            write_cfg(CFG_INDEX_W'($urandom_range(IDX_UNMAPPED_TOP, REG_BASE + 1)),
                      {$urandom, $urandom});
        close_cfg();
    endtask

    task automatic random_region();
        int unsigned plen, kind, pos, rlen;
        plen = sb.active_length();
        kind = $urandom_range(99);
        if (kind < 15) begin
            rlen = $urandom_range(plen + 16, 1);
            pos  = rlen;
        end else if (kind < 25) begin
            rlen = plen > 1 ? $urandom_range(plen - 1, 1) : 1;
            pos  = rlen;
        end else begin
            pos  = $urandom_range(12);
            rlen = pos + plen + $urandom_range(12);
            // pattern cut off by the end of the region
            if (kind < 40 && plen > 1) rlen = pos + $urandom_range(plen - 1, 1);
        end
        repeat (rlen) region_buf.push_back(8'($urandom));
        for (int unsigned k = 0; k < plen; k++)
            if (pos + k < rlen && sb.care_mask[k]) region_buf[pos+k] = sb.pattern_byte(k);
        send_region_buf();
    endtask

    initial begin
        bit first_phase;
        sb        = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        m_tready  <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one wildcard byte matches at once
        region_buf = {8'h00};
        send_region_buf();
        wait_idle();

        write_cfg(REG_PATTERN0, 64'h0123_4567_A55A_FF00);
        write_cfg(REG_PATTERN1, '1);
        write_cfg(REG_PATTERN2, '0);
        write_cfg(REG_PATTERN3, {$urandom, $urandom});
        write_cfg(REG_PATTERN4, '1);
        write_cfg(REG_CARE, '1);
        write_cfg(REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFC4);
        write_cfg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_cfg(IDX_UNMAPPED_TOP, {$urandom, $urandom});
        close_cfg();
        region_buf = {8'h00, 8'hFF, 8'h5A};
        send_region_buf();
        region_buf = {8'h11, 8'h00, 8'hFF, 8'h5A};
        send_region_buf();
        region_buf = {8'h00, 8'hFF, 8'h5A, 8'hA5};
        send_region_buf();
        // match address wraps past the top of the address space
        region_buf = {8'h22, 8'h33, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'hFF};
        send_region_buf();
        wait_idle();

        // zero length acts as one byte
        write_cfg(REG_LENGTH, 64'h0000_0000_0000_0040);
        close_cfg();
        region_buf = {8'hFF, 8'h00, 8'hFF};
        send_region_buf();
        wait_idle();

        // oversize length clamps to the full window
        write_cfg(REG_LENGTH, 64'h0000_0000_0000_003F);
        write_cfg(REG_CARE, '0);
        close_cfg();
        region_buf = {8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        send_region_buf();

        first_phase = 1'b1;
        while (bytes_sent < 900) begin
            wait_idle();
            random_config(first_phase);
            first_phase = 1'b0;
            repeat ($urandom_range(6, 2)) random_region();
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
